>>> rtl/core/assert_macros.svh
// assertion macros used by the stencil step rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/hds_pkg.sv
// types and constants of the heat diffusion stencil block
`default_nettype none

package hds_pkg;

	localparam int MAX_GRID_DEF   = 1024;
	localparam int VALUE_BITS_DEF = 24;

	localparam int SIZE_W     = 11;
	localparam int COEF_W     = 14;
	localparam int FRAC_BITS  = 16;
	localparam int PADDR_W    = 3;
	localparam int GRID_RESET = 128;
	localparam int COEF_RESET = 15729;

	typedef enum logic {
		REG_GRID_SIZE = 1'b0,
		REG_COEF      = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic has_main;   // a cell of the row above comes out
		logic border;     // that cell passes through unchanged
		logic has_extra;  // last row: the arriving cell comes out too
		logic last;       // final cell of the grid
	} cell_flags_t;

endpackage

`default_nettype wire

>>> rtl/core/heat_diffusion_stencil_step.sv
// five-point heat diffusion step over a raster-order cell stream
//
//  channel   dir   handshake                       payload
//  s_*       in    s_tvalid / s_tready             s_tdata: cell_value
//  m_*       out   m_tvalid / m_tready             m_tdata: result_value, m_tlast: last_of_grid
//  apb       in    psel, penable, pwrite, pready   0x0 grid_size, 0x4 diffusion_coefficient
//
// one cell per clock while the output takes results; on the last row each cell gives two
// results, so the single output register drains at one per clock and input runs at half rate there.
// a cell goes memory read, laplacian, multiply, add/saturate: four register stages.
// the previous-row store is read at c and c+1 and written at c when the cell leaves stage 1.
// reset clears control only; line stores hold garbage until the first rows pass.
// stages run on while the output stalls until the pipeline fills.
`default_nettype none

`include "assert_macros.svh"

module heat_diffusion_stencil_step #(
	parameter int MAX_GRID   = hds_pkg::MAX_GRID_DEF,
	parameter int VALUE_BITS = hds_pkg::VALUE_BITS_DEF,
	localparam int DW        = ((VALUE_BITS + 7) / 8) * 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [DW-1:0]               s_tdata,   // cell_value
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [DW-1:0]                    m_tdata,   // result_value
	output logic                             m_tlast,   // last_of_grid
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [hds_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	localparam int AW   = $clog2(MAX_GRID);
	localparam int NWG  = $clog2(MAX_GRID + 1);
	localparam int NW   = (NWG > hds_pkg::SIZE_W) ? NWG : hds_pkg::SIZE_W;
	localparam int LW   = VALUE_BITS + 3;
	localparam int PW   = LW + hds_pkg::COEF_W + 1;
	localparam logic [VALUE_BITS-1:0] VMAX = '1;

	// configuration
	logic [hds_pkg::SIZE_W-1:0] grid_size_q;
	logic [hds_pkg::COEF_W-1:0] coef_q;
	logic                       cfg_wr;
	hds_pkg::reg_idx_t          reg_sel;
	logic                       grid_wr;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = hds_pkg::reg_idx_t'(paddr[2]);
	assign grid_wr = cfg_wr && (reg_sel == hds_pkg::REG_GRID_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= hds_pkg::SIZE_W'(hds_pkg::GRID_RESET);
			coef_q      <= hds_pkg::COEF_W'(hds_pkg::COEF_RESET);
		end else if (cfg_wr) begin
			case (reg_sel)
				hds_pkg::REG_GRID_SIZE: grid_size_q <= pwdata[hds_pkg::SIZE_W-1:0];
				hds_pkg::REG_COEF:      coef_q      <= pwdata[hds_pkg::COEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			hds_pkg::REG_GRID_SIZE: prdata = 32'(grid_size_q);
			hds_pkg::REG_COEF:      prdata = 32'(coef_q);
			default:                prdata = '0;
		endcase
	end

	// effective grid size, saturated to [3, MAX_GRID]
	logic [NW-1:0] gs_ext;
	logic [NW-1:0] n_eff;
	logic [AW-1:0] last_idx;

	assign gs_ext = NW'(grid_size_q);

	always_comb begin
		if (gs_ext < NW'(3))
			n_eff = NW'(3);
		else if (gs_ext > NW'(MAX_GRID))
			n_eff = NW'(MAX_GRID);
		else
			n_eff = gs_ext;
	end

	assign last_idx = AW'(n_eff - NW'(1));

	// pipeline control
	logic v_s1, v_s2, v_s3;
	logic p_main_q, p_extra_q;
	logic out_free, en1, en2, en3, load_out, acc, out_xfer;

	assign out_xfer = m_tvalid && m_tready;
	assign out_free = (!p_main_q && !p_extra_q) || (m_tready && (p_main_q ^ p_extra_q));
	assign load_out = v_s3 && out_free;
	assign en3      = !v_s3 || out_free;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;
	assign acc      = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= acc;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// raster position
	logic [AW-1:0]        row_q, col_q;
	logic                 last_row, last_col;
	hds_pkg::cell_flags_t flags_in;

	assign last_row = (row_q == last_idx);
	assign last_col = (col_q == last_idx);

	always_comb begin
		flags_in.has_main  = (row_q != '0);
		flags_in.border    = (row_q == AW'(1)) || (col_q == '0) || last_col;
		flags_in.has_extra = last_row;
		flags_in.last      = last_row && last_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (grid_wr) begin
			row_q <= '0;
			col_q <= '0;
		end else if (acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + AW'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// line stores
	logic [VALUE_BITS-1:0] prev_mem  [MAX_GRID];
	logic [VALUE_BITS-1:0] older_mem [MAX_GRID];

	logic [AW-1:0]         addr_c, addr_n;
	logic [VALUE_BITS-1:0] prv_c_s1, prv_n_s1, old_s1, x_s1;
	logic [AW-1:0]         col_s1;
	hds_pkg::cell_flags_t  flags_s1;
	logic                  mem_wr;
	logic [VALUE_BITS-1:0] window_q;

	assign addr_c = col_q;
	assign addr_n = col_q + AW'(1);
	assign mem_wr = v_s1 && en2;

	always_ff @(posedge clk) begin
		if (acc) begin
			prv_c_s1 <= prev_mem[addr_c];
			prv_n_s1 <= prev_mem[addr_n];
			old_s1   <= older_mem[addr_c];
			x_s1     <= s_tdata[VALUE_BITS-1:0];
			col_s1   <= col_q;
			flags_s1 <= flags_in;
		end
		// write back when the cell leaves stage 1
		if (mem_wr) begin
			prev_mem[col_s1]  <= x_s1;
			older_mem[col_s1] <= prv_c_s1;
		end
	end

	// left neighbor: previous-row value read by the preceding cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			window_q <= '0;
		else if (grid_wr)
			window_q <= '0;
		else if (mem_wr)
			window_q <= prv_c_s1;
	end

	// stage 2: laplacian
	logic [VALUE_BITS+1:0] nb_sum, x4;
	logic signed [LW-1:0]  lap;
	logic signed [LW-1:0]  lap_s2;
	logic [VALUE_BITS-1:0] center_s2, x_s2;
	hds_pkg::cell_flags_t  flags_s2;

	assign nb_sum = (VALUE_BITS+2)'(window_q) + (VALUE_BITS+2)'(prv_n_s1)
	              + (VALUE_BITS+2)'(old_s1) + (VALUE_BITS+2)'(x_s1);
	assign x4     = {prv_c_s1, 2'b00};
	assign lap    = $signed(LW'(nb_sum)) - $signed(LW'(x4));

	always_ff @(posedge clk) begin
		if (en2) begin
			lap_s2    <= lap;
			center_s2 <= prv_c_s1;
			x_s2      <= x_s1;
			flags_s2  <= flags_s1;
		end
	end

	// stage 3: scale by k
	logic signed [PW-1:0]  prod_s3;
	logic [VALUE_BITS-1:0] center_s3, x_s3;
	hds_pkg::cell_flags_t  flags_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			prod_s3   <= PW'($signed(lap_s2) * $signed({1'b0, coef_q}));
			center_s3 <= center_s2;
			x_s3      <= x_s2;
			flags_s3  <= flags_s2;
		end
	end

	// output: floor shift, add, saturate
	logic signed [PW-1:0]  step_val, sum_val;
	logic [VALUE_BITS-1:0] sat_val;

	assign step_val = prod_s3 >>> hds_pkg::FRAC_BITS;
	assign sum_val  = $signed(PW'(center_s3)) + step_val;

	always_comb begin
		if (sum_val < 0)
			sat_val = '0;
		else if (sum_val > $signed(PW'(VMAX)))
			sat_val = VMAX;
		else
			sat_val = sum_val[VALUE_BITS-1:0];
	end

	logic [VALUE_BITS-1:0] main_val_q, extra_val_q;
	logic                  extra_last_q;

	always_ff @(posedge clk) begin
		if (load_out) begin
			main_val_q   <= flags_s3.border ? center_s3 : sat_val;
			extra_val_q  <= x_s3;
			extra_last_q <= flags_s3.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_main_q  <= 1'b0;
			p_extra_q <= 1'b0;
		end else if (load_out) begin
			p_main_q  <= flags_s3.has_main;
			p_extra_q <= flags_s3.has_extra;
		end else if (out_xfer) begin
			// the row-above result goes first, then the last-row cell
			if (p_main_q)
				p_main_q <= 1'b0;
			else
				p_extra_q <= 1'b0;
		end
	end

	assign m_tvalid = p_main_q || p_extra_q;
	assign m_tdata  = DW'(p_main_q ? main_val_q : extra_val_q);
	assign m_tlast  = !p_main_q && extra_last_q;

	`ASSERT_IMPLY(a_stall_holds_cell, clk, arst_n, !s_tready, v_s1 && !en2)
	`ASSERT_IMPLY(a_no_rw_collision, clk, arst_n, mem_wr && acc,
		(col_s1 != addr_c) && (col_s1 != addr_n))
	`ASSERT_NEXT(a_grid_wraps, clk, arst_n, acc && !grid_wr && last_row && last_col,
		(row_q == '0) && (col_q == '0))

endmodule

`default_nettype wire

>>> tb/tb.sv
// self-checking testbench for the five-point heat diffusion step block
`timescale 1ns / 100ps

module tb;

	localparam int          ROW_CAP      = 1024;
	localparam int          DRAIN_CYCLES = 16;
	localparam int          HOLD_CYCLES  = 300;
	localparam logic [23:0] CELL_MAX     = 24'hFF_FFFF;
	localparam longint      CELL_TOP     = 64'h0000_0000_00FF_FFFF;

	typedef struct packed {
		logic [23:0] value;
		logic        last;
	} cell_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;   // cell_value
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;         // result_value
	logic        m_tlast;         // last_of_grid
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	// predictor copy of the block state and registers
	logic [10:0] cfg_size   = 11'(hds_pkg::GRID_RESET);
	logic [13:0] cfg_coef   = 14'(hds_pkg::COEF_RESET);
	logic [23:0] above_row  [ROW_CAP];
	logic [23:0] two_up_row [ROW_CAP];
	logic [23:0] left_of_center = '0;
	int unsigned row_at = 0;
	int unsigned col_at = 0;

	cell_result_t expected_cells[$];
	int unsigned  mismatches  = 0;
	bit           quiet       = 1'b0;
	bit           sender_gaps = 1'b1;
	bit           hold_output = 1'b0;

	heat_diffusion_stencil_step dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #2 clk = ~clk;

	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic int unsigned grid_n();
		if (cfg_size < 11'd3)
			return 3;
		if (cfg_size > 11'(ROW_CAP))
			return ROW_CAP;
		return int'(cfg_size);
	endfunction

	function automatic logic [23:0] diffuse(input logic [23:0] x, input logic [23:0] l,
			input logic [23:0] r, input logic [23:0] t, input logic [23:0] b);
		longint lap;
		longint v;
		lap = longint'(l) + longint'(r) + longint'(t) + longint'(b) - 4 * longint'(x);
		// arithmetic shift gives floor for negative laplacians
		v = longint'(x) + ((lap * longint'(cfg_coef)) >>> 16);
		if (v < 0)
			return '0;
		if (v > CELL_TOP)
			return CELL_MAX;
		return v[23:0];
	endfunction

	function automatic void predict_cell(input logic [23:0] x);
		int unsigned  n;
		int unsigned  r;
		int unsigned  c;
		cell_result_t res;
		n = grid_n();
		r = row_at;
		c = col_at;
		if (r >= n || c >= n) begin
			r = 0;
			c = 0;
		end
		if (r >= 1) begin
			res.value = above_row[c];
			res.last  = 1'b0;
			if (!(r == 1 || c == 0 || c + 1 == n))
				res.value = diffuse(above_row[c], left_of_center, above_row[c + 1],
					two_up_row[c], x);
			expected_cells.push_back(res);
		end
		left_of_center = above_row[c];
		two_up_row[c]  = above_row[c];
		above_row[c]   = x;
		// last row: the arriving cell is a border cell and comes out right behind
		if (r + 1 == n) begin
			res.value = x;
			res.last  = (c + 1 == n);
			expected_cells.push_back(res);
		end
		c++;
		if (c >= n) begin
			c = 0;
			r++;
			if (r >= n)
				r = 0;
		end
		row_at = r;
		col_at = c;
	endfunction

	function automatic logic [23:0] pick_cell();
		case ($urandom_range(0, 4))
			0: return 24'hFF_0000 | 24'($urandom_range(0, 16'hFFFF));
			1: return 24'($urandom_range(0, 255));
			2: return $urandom_range(0, 1) ? CELL_MAX : 24'd0;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_coef();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'd16383;
			default: return 32'($urandom_range(0, 16383));
		endcase
	endfunction

	// output side: random stalls, one long hold on request
	initial begin
		int unsigned span;
		wait (arst_n);
		forever begin
			if (hold_output) begin
				hold_output = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				span = $urandom_range(1, 17);
				repeat (span) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				span = $urandom_range(1, 20);
				repeat (span) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		cell_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_cells.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected transfer, expected none, actual value %h last %b",
					$time, m_tdata, m_tlast);
			end else begin
				want = expected_cells.pop_front();
				if (m_tdata !== want.value) begin
					mismatches++;
					$display("%0t: result_value expected %h actual %h", $time, want.value,
						m_tdata);
				end
				if (m_tlast !== want.last) begin
					mismatches++;
					$display("%0t: last_of_grid expected %b actual %b", $time, want.last,
						m_tlast);
				end
			end
		end
	end

	task automatic send_cell(input logic [23:0] value);
		int unsigned span;
		if (!quiet && sender_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			span = $urandom_range(1, 17);
			repeat (span) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_cell(value);
	endtask

	task automatic send_random_cells(input int unsigned count);
		int unsigned i;
		for (i = 0; i < count; i++)
			send_cell(pick_cell());
	endtask

	// row-0 cells leave no result behind, so give the pipeline time to finish
	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_cells.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input hds_pkg::reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx == hds_pkg::REG_GRID_SIZE) begin
			cfg_size       = value[10:0];
			row_at         = 0;
			col_at         = 0;
			left_of_center = '0;
		end else begin
			cfg_coef = value[13:0];
		end
	endtask

	task automatic reg_read(input hds_pkg::reg_idx_t idx, output logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		value = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_regs();
		logic [31:0] got;
		reg_read(hds_pkg::REG_GRID_SIZE, got);
		if (got !== {21'd0, cfg_size}) begin
			mismatches++;
			$display("%0t: grid_size readback expected %h actual %h", $time,
				{21'd0, cfg_size}, got);
		end
		reg_read(hds_pkg::REG_COEF, got);
		if (got !== {18'd0, cfg_coef}) begin
			mismatches++;
			$display("%0t: diffusion_coefficient readback expected %h actual %h", $time,
				{18'd0, cfg_coef}, got);
		end
	endtask

	// two rows and a part of the third, so interior cells of row 1 come out
	task automatic test_reset_defaults();
		check_regs();
		send_random_cells(2 * hds_pkg::GRID_RESET + 32);
		settle();
	endtask

	// checkerboards of zero and full scale, strongest coefficient, smallest grids
	task automatic test_border_extremes();
		int unsigned r;
		int unsigned c;
		reg_write(hds_pkg::REG_GRID_SIZE, 32'd0);
		reg_write(hds_pkg::REG_COEF, 32'd16383);
		check_regs();
		for (r = 0; r < 3; r++)
			for (c = 0; c < 3; c++)
				send_cell(((r + c) % 2) ? CELL_MAX : 24'd0);
		settle();
		reg_write(hds_pkg::REG_GRID_SIZE, 32'd4);
		for (r = 0; r < 4; r++)
			for (c = 0; c < 4; c++)
				send_cell(((r + c) % 2) ? 24'd0 : CELL_MAX);
		settle();
	endtask

	// a size above the store depth reads back as written; a part of row 0 gives nothing
	task automatic test_large_grid();
		reg_write(hds_pkg::REG_GRID_SIZE, 32'd2047);
		reg_write(hds_pkg::REG_COEF, pick_coef());
		check_regs();
		send_random_cells(64);
		settle();
	endtask

	task automatic test_output_hold();
		reg_write(hds_pkg::REG_GRID_SIZE, 32'd8);
		reg_write(hds_pkg::REG_COEF, pick_coef());
		sender_gaps = 1'b0;
		hold_output = 1'b1;
		send_random_cells(64);
		sender_gaps = 1'b1;
		settle();
	endtask

	task automatic test_random_grids();
		int unsigned total;
		int unsigned n;
		int unsigned cut;
		int unsigned coef_at;
		int unsigned i;
		logic [10:0] size_raw;
		total = 0;
		while (total < 560) begin
			case ($urandom_range(0, 9))
				0: size_raw = 11'($urandom_range(0, 2));
				1: size_raw = 11'd3;
				default: size_raw = 11'($urandom_range(4, 14));
			endcase
			reg_write(hds_pkg::REG_GRID_SIZE, 32'(size_raw));
			reg_write(hds_pkg::REG_COEF, pick_coef());
			if ($urandom_range(0, 3) == 0)
				check_regs();
			n = grid_n();
			// some grids are cut short and restarted by the next size write
			cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n * n - 1) : n * n;
			coef_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, cut) : 0;
			for (i = 0; i < cut; i++) begin
				if (coef_at != 0 && i == coef_at) begin
					settle();
					reg_write(hds_pkg::REG_COEF, pick_coef());
				end
				if (total >= 420)
					quiet = 1'b1;
				send_cell(pick_cell());
				total++;
			end
			settle();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_border_extremes();
		test_large_grid();
		test_output_hold();
		test_random_grids();
		settle();
		if (mismatches == 0 && expected_cells.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/hds_pkg.sv
rtl/core/heat_diffusion_stencil_step.sv
tb/tb.sv
